// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL; versioned_update_store includes them. ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// A condition in one cycle that implies another condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/vus_pkg.sv =====
// ----------------------------------------------------------------------------
// vus_pkg
// Types, field widths and codes of the versioned update store.
// ----------------------------------------------------------------------------
`default_nettype none

package vus_pkg;

    localparam int KEY_W     = 16;
    localparam int SOURCE_W  = 8;
    localparam int VERSION_W = 16;
    localparam int STAMP_W   = 31;
    localparam int MAX_W     = 5;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;

    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam logic [MAX_W-1:0] MAX_ENTRIES_RESET = 5'd16;

    // One stored update record.
    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [SOURCE_W-1:0]  source;
        logic [VERSION_W-1:0] version;
        logic [STAMP_W-1:0]   stamp;
    } t_rec;

    // What every cell of the chain does in one cycle.
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op OP_HOLD      = 2'd0;
    localparam t_cell_op OP_ROTATE    = 2'd1;
    localparam t_cell_op OP_SHIFT_INS = 2'd2;
    localparam t_cell_op OP_APPEND    = 2'd3;

    localparam logic [KIND_W-1:0] KIND_STORE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DUMPED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_NONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_APPENDED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REPLACED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_STALE    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EVICTED  = 2'd3;

    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_DUMP  = 1'b1;

endpackage

`default_nettype wire

// ===== sv/vus_cell.sv =====
// ----------------------------------------------------------------------------
// vus_cell
// One slot of the record chain: rotates, closes gaps and takes appends.
// ----------------------------------------------------------------------------
`default_nettype none

module vus_cell #(
    parameter int TABLE_DEPTH = vus_pkg::DEFAULT_TABLE_DEPTH,
    parameter int IDX         = 0
) (
    input  wire                                 i_clk,
    input  wire vus_pkg::t_cell_op              i_op,
    input  wire [$clog2(TABLE_DEPTH+1)-1:0]     i_count,
    input  wire [$clog2(TABLE_DEPTH+1)-1:0]     i_pos,
    input  wire vus_pkg::t_rec                  i_right,
    input  wire vus_pkg::t_rec                  i_head,
    input  wire vus_pkg::t_rec                  i_new,
    output vus_pkg::t_rec                       o_rec
);
    import vus_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
    localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

    t_rec r_rec;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_HOLD: begin
            end
            OP_ROTATE: begin
                // The head record wraps around to the tail slot.
                if (MY_NEXT == i_count) begin
                    r_rec <= i_head;
                end else if (MY_NEXT < i_count) begin
                    r_rec <= i_right;
                end
            end
            OP_SHIFT_INS: begin
                // Remove the record at i_pos and put the new one at the tail.
                if (MY_NEXT == i_count) begin
                    r_rec <= i_new;
                end else if (MY_IDX >= i_pos && MY_NEXT < i_count) begin
                    r_rec <= i_right;
                end
            end
            OP_APPEND: begin
                if (MY_IDX == i_count) begin
                    r_rec <= i_new;
                end
            end
        endcase
    end

    assign o_rec = r_rec;

endmodule

`default_nettype wire

// ===== sv/versioned_update_store.sv =====
// ----------------------------------------------------------------------------
// versioned_update_store
// Ordered table of update records with versioned replace and eviction.
// ----------------------------------------------------------------------------
// Usage. An input word (i_func and the record fields) is taken when i_valid
// is high and o_stall is low. A store word gives one result word; a dump
// word gives one result word per stored record in list order, with o_last on
// the final one, or a single word of kind empty when the table holds nothing.
// Result words leave on o_valid and are held while i_stall is high.
// The records live in a chain of cells; cell 0 is the list head. Every
// search or dump rotates the whole list once through cell 0. A store
// scans the list, decides its outcome once the whole list has been seen,
// applies its edit to the chain and then loads its result into the output
// register. A dump produces one word per cycle, as fast as the receiver
// takes them. One word is handled at a time; o_stall stays high until the
// last result of the current word sits in the output register. A stalled
// receiver delays a store only at its final output load and holds back a
// dump's rotation; the table keeps its content. Synchronous reset empties
// the table (record count zero) and sets max_entries to 16; record storage
// is not cleared. max_entries is written with i_cfg_we and is meant to
// change only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module versioned_update_store #(
    parameter int TABLE_DEPTH = vus_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration
    input  wire                              i_cfg_we,
    input  wire [vus_pkg::MAX_W-1:0]         i_cfg_data,
    // input channel
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire                              i_func,
    input  wire [vus_pkg::KEY_W-1:0]         i_rec_key,
    input  wire [vus_pkg::SOURCE_W-1:0]      i_rec_source,
    input  wire [vus_pkg::VERSION_W-1:0]     i_rec_version,
    input  wire [vus_pkg::STAMP_W-1:0]       i_rec_stamp,
    // output channel
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [vus_pkg::KIND_W-1:0]       o_kind,
    output logic [vus_pkg::STATUS_W-1:0]     o_status,
    output logic [vus_pkg::KEY_W-1:0]        o_out_key,
    output logic [vus_pkg::SOURCE_W-1:0]     o_out_source,
    output logic [vus_pkg::VERSION_W-1:0]    o_out_version,
    output logic [vus_pkg::STAMP_W-1:0]      o_out_stamp,
    output logic                             o_last
);
    import vus_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > MAX_W) ? CW : MAX_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EDIT = 3'd2;
    localparam logic [2:0] S_POST = 3'd3;
    localparam logic [2:0] S_DUMP = 3'd4;

    // Sequencer and table control.
    logic [2:0]        r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic [MAX_W-1:0]  r_max;
    logic              r_func;
    t_rec              r_item;

    // Search results gathered during the scan.
    logic              r_match;
    logic [CW-1:0]     r_match_pos;
    logic              r_newer;
    logic              r_best_vld;
    logic [CW-1:0]     r_best_pos;
    t_rec              r_best;

    // Decided store outcome.
    t_cell_op          r_edit_op;
    logic [CW-1:0]     r_edit_pos;
    logic [STATUS_W-1:0] r_res_status;
    t_rec              r_res_rec;

    // Output register.
    logic              r_out_valid;
    logic [KIND_W-1:0] r_out_kind;
    logic [STATUS_W-1:0] r_out_status;
    t_rec              r_out_rec;
    logic              r_out_last;

    // Chain wiring.
    t_rec              w_rec   [TABLE_DEPTH];
    t_rec              w_right [TABLE_DEPTH];
    t_rec              w_head;
    t_cell_op          w_op;
    logic              w_out_free;
    logic              w_accept;
    logic              w_hit;
    logic              w_take_min;
    logic [LW-1:0]     w_max_ext;
    logic [LW-1:0]     w_limit;
    logic              w_below_limit;
    logic              w_dump_last;

    assign w_head     = w_rec[0];
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            if (g == TABLE_DEPTH - 1) begin : g_end
                assign w_right[g] = w_head;
            end else begin : g_mid
                assign w_right[g] = w_rec[g + 1];
            end
            vus_cell #(
                .TABLE_DEPTH (TABLE_DEPTH),
                .IDX         (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_count (r_count),
                .i_pos   (r_edit_pos),
                .i_right (w_right[g]),
                .i_head  (w_head),
                .i_new   (r_item),
                .o_rec   (w_rec[g])
            );
        end
    endgenerate

    // Effective limit: zero acts as one, anything above the depth as the depth.
    assign w_max_ext = LW'(r_max);
    always_comb begin
        if (r_max == '0) begin
            w_limit = LW'(1);
        end else if (w_max_ext > LW'(TABLE_DEPTH)) begin
            w_limit = LW'(TABLE_DEPTH);
        end else begin
            w_limit = w_max_ext;
        end
    end
    assign w_below_limit = LW'(r_count) < w_limit;

    // The head record is compared while it passes through cell 0.
    assign w_hit = (w_head.source == r_item.source) && (w_head.key == r_item.key);
    // Strict compare keeps the first record with the smallest stamp.
    assign w_take_min  = !r_best_vld || (w_head.stamp < r_best.stamp);
    assign w_dump_last = (r_idx + CW'(1)) == r_count;

    always_comb begin
        w_op = OP_HOLD;
        unique case (r_state)
            S_SCAN: begin
                if (r_idx != r_count) begin
                    w_op = OP_ROTATE;
                end
            end
            S_DUMP: begin
                if (r_count != '0 && w_out_free) begin
                    w_op = OP_ROTATE;
                end
            end
            S_EDIT: begin
                w_op = r_edit_op;
            end
            default: begin
                w_op = OP_HOLD;
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_ENTRIES_RESET;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_data;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_match    <= 1'b0;
            r_best_vld <= 1'b0;
            r_edit_op  <= OP_HOLD;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx      <= '0;
                        r_match    <= 1'b0;
                        r_best_vld <= 1'b0;
                        r_state    <= (i_func == FUNC_DUMP) ? S_DUMP : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx != r_count) begin
                        if (w_hit && !r_match) begin
                            r_match     <= 1'b1;
                            r_match_pos <= r_idx;
                            r_newer     <= r_item.version > w_head.version;
                        end
                        if (w_take_min) begin
                            r_best_vld <= 1'b1;
                            r_best_pos <= r_idx;
                            r_best     <= w_head;
                        end
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        // Whole list seen and back in its original order.
                        r_state <= S_EDIT;
                        if (r_match && !r_newer) begin
                            r_res_status <= STAT_STALE;
                            r_res_rec    <= '0;
                            r_edit_op    <= OP_HOLD;
                            r_edit_pos   <= r_match_pos;
                        end else if (r_match) begin
                            r_res_status <= STAT_REPLACED;
                            r_res_rec    <= '0;
                            r_edit_op    <= OP_SHIFT_INS;
                            r_edit_pos   <= r_match_pos;
                        end else if (w_below_limit) begin
                            r_res_status <= STAT_APPENDED;
                            r_res_rec    <= '0;
                            r_edit_op    <= OP_APPEND;
                            r_edit_pos   <= r_match_pos;
                        end else if (!r_best_vld || (r_item.stamp < r_best.stamp)) begin
                            // The new record itself is the oldest one.
                            r_res_status <= STAT_EVICTED;
                            r_res_rec    <= r_item;
                            r_edit_op    <= OP_HOLD;
                            r_edit_pos   <= r_match_pos;
                        end else begin
                            r_res_status <= STAT_EVICTED;
                            r_res_rec    <= r_best;
                            r_edit_op    <= OP_SHIFT_INS;
                            r_edit_pos   <= r_best_pos;
                        end
                    end
                end
                S_EDIT: begin
                    if (r_edit_op == OP_APPEND) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_DUMP: begin
                    if (w_out_free) begin
                        if (r_count == '0 || w_dump_last) begin
                            r_state <= S_IDLE;
                        end
                        r_idx <= r_idx + CW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Incoming record, latched when the word is taken.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_func;
            r_item <= '{key: i_rec_key, source: i_rec_source,
                        version: i_rec_version, stamp: i_rec_stamp};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_POST && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_state == S_DUMP && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_POST && w_out_free) begin
            r_out_kind   <= KIND_STORE;
            r_out_status <= r_res_status;
            r_out_rec    <= r_res_rec;
            r_out_last   <= 1'b1;
        end else if (r_state == S_DUMP && w_out_free) begin
            r_out_status <= STAT_NONE;
            if (r_count == '0) begin
                r_out_kind <= KIND_EMPTY;
                r_out_rec  <= '0;
                r_out_last <= 1'b1;
            end else begin
                r_out_kind <= KIND_DUMPED;
                r_out_rec  <= w_head;
                r_out_last <= w_dump_last;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_status      = r_out_status;
    assign o_out_key     = r_out_rec.key;
    assign o_out_source  = r_out_rec.source;
    assign o_out_version = r_out_rec.version;
    assign o_out_stamp   = r_out_rec.stamp;
    assign o_last        = r_out_last;

    // The table never holds more records than it has cells.
    `ASSERT_ALWAYS(a_count_in_range, i_clk, i_rst_n, r_count <= CW'(TABLE_DEPTH))
    // A taken word always starts work in the next cycle.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state != S_IDLE)
    // An edit grows the table by at most one record.
    `ASSERT_NEXT(a_edit_count, i_clk, i_rst_n, r_state == S_EDIT, (r_count - $past(r_count)) <= CW'(1))
    // The func of a word being scanned is a store.
    `ASSERT_ALWAYS(a_scan_is_store, i_clk, i_rst_n, r_state != S_SCAN || r_func == FUNC_STORE)

endmodule

`default_nettype wire

// ===== test/versioned_update_store_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// versioned_update_store_tb
// Self-checking bench for the versioned update store. A directed table of
// words, some with hand-written results, is followed by random phases under
// several max_entries settings and idling patterns. Every result word is
// compared field by field with the row's own result or the shadow table's prediction.
// ----------------------------------------------------------------------------
module versioned_update_store_tb;

    import vus_pkg::*;

    localparam int TABLE_DEPTH    = DEFAULT_TABLE_DEPTH;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int POOL_SIZE      = 20;
    localparam int N_PHASES       = 7;
    localparam t_rec NO_REC       = '0;

    // One expected result word.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [STATUS_W-1:0] status;
        t_rec                rec;
        logic                last;
    } out_word_t;

    typedef enum logic [1:0] {ROW_STORE, ROW_DUMP, ROW_CFG} row_op_e;

    // One row of the directed table. When typed is set, the result is the
    // single word written in the row; otherwise the shadow table decides.
    typedef struct packed {
        row_op_e             op;
        t_rec                rec;
        logic [MAX_W-1:0]    cfg;
        logic                typed;
        logic [KIND_W-1:0]   want_kind;
        logic [STATUS_W-1:0] want_status;
        t_rec                want_rec;
    } stim_row_t;

    // Bench-side drivers; all of them hold a known value from time zero.
    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_we     = 1'b0;
    logic [MAX_W-1:0] cfg_data   = '0;
    logic             word_valid = 1'b0;
    logic             word_func  = FUNC_STORE;
    t_rec             word_rec   = '0;
    logic             rx_stall   = 1'b0;

    wire                 busy;
    wire                 res_valid;
    wire [KIND_W-1:0]    res_kind;
    wire [STATUS_W-1:0]  res_status;
    wire [KEY_W-1:0]     res_key;
    wire [SOURCE_W-1:0]  res_source;
    wire [VERSION_W-1:0] res_version;
    wire [STAMP_W-1:0]   res_stamp;
    wire                 res_last;

    // Shadow copy of the record table and the limit register.
    t_rec             shadow_tbl[TABLE_DEPTH];
    int               shadow_count = 0;
    logic [MAX_W-1:0] max_setting  = MAX_ENTRIES_RESET;

    out_word_t expected_words[$];
    stim_row_t dir_rows[$];
    int        err_count = 0;

    // Idling controls, written by the main sequence.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_token      = 0;

    versioned_update_store uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_valid       (word_valid),
        .o_stall       (busy),
        .i_func        (word_func),
        .i_rec_key     (word_rec.key),
        .i_rec_source  (word_rec.source),
        .i_rec_version (word_rec.version),
        .i_rec_stamp   (word_rec.stamp),
        .o_valid       (res_valid),
        .i_stall       (rx_stall),
        .o_kind        (res_kind),
        .o_status      (res_status),
        .o_out_key     (res_key),
        .o_out_source  (res_source),
        .o_out_version (res_version),
        .o_out_stamp   (res_stamp),
        .o_last        (res_last)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------

    function automatic void expect_word(logic [KIND_W-1:0] kind,
                                        logic [STATUS_W-1:0] status,
                                        t_rec rec, logic last);
        out_word_t w;
        w.kind   = kind;
        w.status = status;
        w.rec    = rec;
        w.last   = last;
        expected_words.push_back(w);
    endfunction

    // Removing a record closes the gap, so list order is kept.
    task automatic drop_record(input int pos);
        for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_tbl[i] = shadow_tbl[i + 1];
        end
        shadow_count--;
    endtask

    task automatic add_record(input t_rec r);
        if (shadow_count < TABLE_DEPTH) begin
            shadow_tbl[shadow_count] = r;
            shadow_count++;
        end
    endtask

    // Works out the result words of one accepted word and updates the
    // shadow table the way the block is expected to update its own.
    task automatic predict_word(input logic func, input t_rec r);
        int               hit;
        int               lim;
        int               victim;
        logic [STAMP_W-1:0] best;
        logic [STAMP_W-1:0] ts;
        hit = -1;
        if (func == FUNC_DUMP) begin
            if (shadow_count == 0) begin
                expect_word(KIND_EMPTY, STAT_NONE, NO_REC, 1'b1);
            end else begin
                for (int i = 0; i < shadow_count; i++) begin
                    expect_word(KIND_DUMPED, STAT_NONE, shadow_tbl[i],
                                (i == shadow_count - 1));
                end
            end
        end else begin
            for (int i = 0; i < shadow_count; i++) begin
                if (hit < 0 && shadow_tbl[i].source == r.source &&
                    shadow_tbl[i].key == r.key) begin
                    hit = i;
                end
            end
            // A zero limit behaves as one, anything past the depth as the depth.
            lim = int'(max_setting);
            if (lim == 0) lim = 1;
            if (lim > TABLE_DEPTH) lim = TABLE_DEPTH;
            if (hit >= 0) begin
                // Only a strictly newer version replaces; the winner moves to the tail.
                if (r.version > shadow_tbl[hit].version) begin
                    drop_record(hit);
                    add_record(r);
                    expect_word(KIND_STORE, STAT_REPLACED, NO_REC, 1'b1);
                end else begin
                    expect_word(KIND_STORE, STAT_STALE, NO_REC, 1'b1);
                end
            end else if (shadow_count + 1 <= lim) begin
                add_record(r);
                expect_word(KIND_STORE, STAT_APPENDED, NO_REC, 1'b1);
            end else begin
                // The incoming record sits after the stored ones; the first
                // smallest stamp in that order loses, ties going to the front.
                victim = 0;
                best   = (shadow_count > 0) ? shadow_tbl[0].stamp : r.stamp;
                for (int i = 1; i <= shadow_count; i++) begin
                    ts = (i < shadow_count) ? shadow_tbl[i].stamp : r.stamp;
                    if (ts < best) begin
                        best   = ts;
                        victim = i;
                    end
                end
                if (victim == shadow_count) begin
                    expect_word(KIND_STORE, STAT_EVICTED, r, 1'b1);
                end else begin
                    expect_word(KIND_STORE, STAT_EVICTED, shadow_tbl[victim], 1'b1);
                    drop_record(victim);
                    add_record(r);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offers one word, waits for it to be taken and records what it should
    // produce. Valid is left high after the handshake; the next call either
    // presents a new word or idles, so valid is assigned once per edge.
    task automatic send_word(input logic func, input t_rec r,
                             input logic typed, input out_word_t want);
        int n_before;
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge clk);
            word_valid <= 1'b0;
        end
        @(negedge clk);
        word_valid <= 1'b1;
        word_func  <= func;
        word_rec   <= r;
        do @(posedge clk); while (busy);
        n_before = expected_words.size();
        predict_word(func, r);
        if (typed) begin
            // The row's own result stands in for the shadow table's.
            while (expected_words.size() > n_before) void'(expected_words.pop_back());
            expected_words.push_back(want);
        end
    endtask

    // Stops offering words until every expected result has come out, then
    // waits for the block to settle.
    task automatic wait_drained();
        @(negedge clk);
        word_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The limit register is written only while the block is idle.
    task automatic write_limit(input logic [MAX_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        max_setting = value;
    endtask

    // Receiver side: random stalls at the phase's rate, plus a long hold-off
    // whenever the main sequence bumps hold_token. The hold-off is counted
    // here so the sender keeps offering words while it lasts.
    int hold_seen = 0;
    int hold_left = 0;
    always @(negedge clk) begin
        if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rx_stall <= 1'b1;
        end else begin
            rx_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endfunction

    // Each result word taken from the block is matched with the oldest
    // expectation.
    always @(posedge clk) begin
        out_word_t want;
        if (rst_n && res_valid && !rx_stall) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                err_count++;
            end else begin
                want = expected_words.pop_front();
                check_field("kind", 32'(want.kind), 32'(res_kind));
                check_field("status", 32'(want.status), 32'(res_status));
                check_field("out_key", 32'(want.rec.key), 32'(res_key));
                check_field("out_source", 32'(want.rec.source), 32'(res_source));
                check_field("out_version", 32'(want.rec.version), 32'(res_version));
                check_field("out_stamp", 32'(want.rec.stamp), 32'(res_stamp));
                check_field("last", 32'(want.last), 32'(res_last));
            end
        end
    end

    // Watchdog: a long run of cycles with no word taken on either side
    // means the block has hung.
    int quiet_cycles = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if ((word_valid && !busy) || (res_valid && !rx_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("** versioned_update_store: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    // Per random phase: limit setting, sender idle rate, receiver stall
    // rate and number of words. Phase 4 also carries the long hold-off,
    // phase 1 a pause of the sender until everything has drained.
    int ph_cfg[N_PHASES]   = '{16, 1, 31, 0, 5, 16, 3};
    int ph_send[N_PHASES]  = '{0, 79, 0, 12, 0, 12, 79};
    int ph_recv[N_PHASES]  = '{0, 0, 79, 12, 0, 12, 0};
    int ph_words[N_PHASES] = '{40, 30, 35, 30, 30, 40, 25};

    logic [KEY_W-1:0]    pool_key[POOL_SIZE];
    logic [SOURCE_W-1:0] pool_src[POOL_SIZE];

    initial begin
        stim_row_t row;
        out_word_t want;
        t_rec      rec;
        logic      func;
        int        pick;
        int        idx;

        // Directed table. The first rows walk the basic statuses with the
        // extreme field values, then the limit is dropped below the record
        // count, set to zero and set past the depth.
        dir_rows.push_back('{ROW_DUMP, NO_REC, 5'd0, 1'b1, KIND_EMPTY, STAT_NONE, NO_REC});
        dir_rows.push_back('{ROW_STORE, '{16'h0000, 8'h00, 16'h0000, 31'h0}, 5'd0,
                             1'b1, KIND_STORE, STAT_APPENDED, NO_REC});
        dir_rows.push_back('{ROW_STORE, '{16'hFFFF, 8'hFF, 16'hFFFF, 31'h7FFFFFFF}, 5'd0,
                             1'b1, KIND_STORE, STAT_APPENDED, NO_REC});
        // Equal version is stale.
        dir_rows.push_back('{ROW_STORE, '{16'h0000, 8'h00, 16'h0000, 31'd9}, 5'd0,
                             1'b1, KIND_STORE, STAT_STALE, NO_REC});
        // Smaller version against the largest one, unsigned compare.
        dir_rows.push_back('{ROW_STORE, '{16'hFFFF, 8'hFF, 16'h0000, 31'd1}, 5'd0,
                             1'b1, KIND_STORE, STAT_STALE, NO_REC});
        dir_rows.push_back('{ROW_STORE, '{16'h0000, 8'h00, 16'h0001, 31'd100}, 5'd0,
                             1'b1, KIND_STORE, STAT_REPLACED, NO_REC});
        // Same key, other source and same source, other key are new records.
        dir_rows.push_back('{ROW_STORE, '{16'h0000, 8'hFF, 16'h0002, 31'd50}, 5'd0,
                             1'b1, KIND_STORE, STAT_APPENDED, NO_REC});
        dir_rows.push_back('{ROW_STORE, '{16'hFFFF, 8'h00, 16'h0003, 31'd50}, 5'd0,
                             1'b1, KIND_STORE, STAT_APPENDED, NO_REC});
        dir_rows.push_back('{ROW_DUMP, NO_REC, 5'd0, 1'b0, KIND_STORE, STAT_NONE, NO_REC});
        dir_rows.push_back('{ROW_CFG, NO_REC, 5'd2, 1'b0, KIND_STORE, STAT_NONE, NO_REC});
        // Two records tie on the smallest stamp; the earlier one goes.
        dir_rows.push_back('{ROW_STORE, '{16'h0001, 8'h01, 16'h0001, 31'd60}, 5'd0,
                             1'b0, KIND_STORE, STAT_NONE, NO_REC});
        // The incoming record has the smallest stamp and is itself evicted.
        dir_rows.push_back('{ROW_STORE, '{16'h0002, 8'h02, 16'h0002, 31'd0}, 5'd0,
                             1'b1, KIND_STORE, STAT_EVICTED,
                             '{16'h0002, 8'h02, 16'h0002, 31'd0}});
        dir_rows.push_back('{ROW_DUMP, NO_REC, 5'd0, 1'b0, KIND_STORE, STAT_NONE, NO_REC});
        dir_rows.push_back('{ROW_CFG, NO_REC, 5'd0, 1'b0, KIND_STORE, STAT_NONE, NO_REC});
        dir_rows.push_back('{ROW_STORE, '{16'h0003, 8'h03, 16'h0003, 31'd40}, 5'd0,
                             1'b0, KIND_STORE, STAT_NONE, NO_REC});
        dir_rows.push_back('{ROW_STORE, '{16'hFFFF, 8'h00, 16'h0004, 31'd7}, 5'd0,
                             1'b1, KIND_STORE, STAT_REPLACED, NO_REC});
        dir_rows.push_back('{ROW_STORE, '{16'hFFFF, 8'hFF, 16'hFFFF, 31'd3}, 5'd0,
                             1'b1, KIND_STORE, STAT_STALE, NO_REC});
        dir_rows.push_back('{ROW_STORE, '{16'h0003, 8'h03, 16'h0003, 31'd5000}, 5'd0,
                             1'b0, KIND_STORE, STAT_NONE, NO_REC});
        dir_rows.push_back('{ROW_DUMP, NO_REC, 5'd0, 1'b0, KIND_STORE, STAT_NONE, NO_REC});
        dir_rows.push_back('{ROW_CFG, NO_REC, 5'd31, 1'b0, KIND_STORE, STAT_NONE, NO_REC});
        // A limit past the depth acts as the depth, so this one fits.
        dir_rows.push_back('{ROW_STORE, '{16'h0004, 8'h04, 16'h0004, 31'd1}, 5'd0,
                             1'b1, KIND_STORE, STAT_APPENDED, NO_REC});
        dir_rows.push_back('{ROW_CFG, NO_REC, 5'd16, 1'b0, KIND_STORE, STAT_NONE, NO_REC});
        dir_rows.push_back('{ROW_DUMP, NO_REC, 5'd0, 1'b0, KIND_STORE, STAT_NONE, NO_REC});

        // Reset first; the table starts empty with a limit of 16.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        shadow_count = 0;
        max_setting  = MAX_ENTRIES_RESET;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.op == ROW_CFG) begin
                wait_drained();
                write_limit(row.cfg);
            end else begin
                want.kind   = row.want_kind;
                want.status = row.want_status;
                want.rec    = row.want_rec;
                want.last   = 1'b1;
                send_word((row.op == ROW_DUMP) ? FUNC_DUMP : FUNC_STORE, row.rec,
                          row.typed, want);
            end
        end

        // A small pool of source/key pairs makes matches, replaces and stale
        // drops common. Half the entries share a key with their neighbor but
        // differ in source.
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_key[i] = (i % 2 == 1) ? pool_key[i - 1] : KEY_W'($urandom);
            pool_src[i] = SOURCE_W'($urandom);
        end

        want = '0;
        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            write_limit(MAX_W'(ph_cfg[p]));
            sender_idle_pct = ph_send[p];
            recv_stall_pct  = ph_recv[p];
            // The receiver goes quiet while words keep coming, so the block
            // backs up and holds its input stalled.
            if (p == 4) hold_token++;
            for (int n = 0; n < ph_words[p]; n++) begin
                if (p == 1 && n == ph_words[p] / 2) wait_drained();
                pick = $urandom_range(99);
                // Full-width random content; a dump ignores it.
                rec.key     = KEY_W'($urandom);
                rec.source  = SOURCE_W'($urandom);
                rec.version = VERSION_W'($urandom);
                rec.stamp   = STAMP_W'($urandom);
                if (pick < 12) begin
                    func = FUNC_DUMP;
                end else begin
                    func = FUNC_STORE;
                    if (pick < 88) begin
                        idx = $urandom_range(POOL_SIZE - 1);
                        rec.key    = pool_key[idx];
                        rec.source = pool_src[idx];
                    end
                    // Small versions and stamps give equal versions and stamp ties.
                    if ($urandom_range(1) == 1) rec.version = VERSION_W'($urandom_range(3));
                    if ($urandom_range(2) == 0) rec.stamp = STAMP_W'($urandom_range(15));
                end
                send_word(func, rec, 1'b0, want);
            end
        end

        // Drain everything, then keep watching for stray words.
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        @(negedge clk);
        word_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        if (err_count == 0 && expected_words.size() == 0) begin
            $display("** versioned_update_store: PASSED **");
        end else begin
            $display("** versioned_update_store: FAILED **");
        end
        $finish;
    end

endmodule
